// ===== rtl/skit_pkg.sv =====
package skit_pkg;

    localparam int KEY_W = 37;
    localparam int POS_W = 16;
    localparam int STATUS_W = 3;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] record_position;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    found_position;
    } t_out_word;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic probe_rd;
        logic probe_cmp;
        logic set_result;
        logic shift_init;
        logic shift_step;
        logic write_new;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic search_open;
        logic need_insert;
        logic no_shift;
        logic shift_last;
        logic full;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/skit_dp.sv =====
module skit_dp
    import skit_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  logic      i_out_ready,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    t_in_word           r_item;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [IDX_W-1:0]   r_mid;
    logic [IDX_W-1:0]   r_dst;
    logic               r_hit, n_hit;
    logic [POS_W-1:0]   r_hit_pos, n_hit_pos;
    t_out_word          r_res, n_res;
    t_out_word          r_out;
    logic               r_out_valid;

    logic [CNT_W-1:0]   w_mid_c;
    logic [IDX_W-1:0]   w_mid;
    logic               w_full;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    t_entry             w_wr_data;
    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;

    assign w_mid_c = r_lo + ((r_hi - r_lo) >> 1);
    assign w_mid   = w_mid_c[IDX_W-1:0];
    assign w_full  = (r_count == CNT_W'(TABLE_DEPTH));

    // memory port selection
    always_comb begin
        w_wr_en   = i_cmd.shift_step | i_cmd.write_new;
        w_wr_addr = i_cmd.write_new ? r_lo[IDX_W-1:0] : r_dst;
        w_wr_data = i_cmd.write_new ? t_entry'({r_item.key, r_item.record_position}) : r_rdata;
        w_rd_en   = i_cmd.probe_rd | i_cmd.shift_init |
                    (i_cmd.shift_step & ~o_stat.shift_last);
        priority if (i_cmd.probe_rd) begin
            w_rd_addr = w_mid;
        end else if (i_cmd.shift_init) begin
            w_rd_addr = IDX_W'(r_count - CNT_W'(1));
        end else begin
            w_rd_addr = r_dst - IDX_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // search bounds, hit tracking, result and entry count
    always_comb begin
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_hit     = r_hit;
        n_hit_pos = r_hit_pos;
        n_res     = r_res;
        n_count   = r_count;
        if (i_cmd.load_item) begin
            n_lo  = '0;
            n_hi  = r_count;
            n_hit = 1'b0;
        end
        if (i_cmd.probe_cmp) begin
            if (r_rdata.key < r_item.key) begin
                n_lo = CNT_W'(r_mid) + CNT_W'(1);
            end else begin
                n_hi = CNT_W'(r_mid);
            end
            // keys are unique, so an equal probe is the lower bound
            if (r_rdata.key == r_item.key) begin
                n_hit     = 1'b1;
                n_hit_pos = r_rdata.pos;
            end
        end
        if (i_cmd.set_result) begin
            n_res.found_position = '0;
            if (r_item.action == ACT_LOOKUP) begin
                if (r_hit) begin
                    n_res.status         = ST_FOUND;
                    n_res.found_position = r_hit_pos;
                end else begin
                    n_res.status = ST_NOT_FOUND;
                end
            end else if (r_hit) begin
                n_res.status = ST_DUPLICATE;
            end else if (w_full) begin
                n_res.status = ST_FULL;
            end else begin
                n_res.status = ST_INSERTED;
            end
        end
        if (i_cmd.write_new) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_hit     <= n_hit;
        r_hit_pos <= n_hit_pos;
        r_res     <= n_res;
        if (i_cmd.load_item) begin
            r_item <= i_in_word;
        end
        if (i_cmd.probe_rd) begin
            r_mid <= w_mid;
        end
        if (i_cmd.shift_init) begin
            r_dst <= r_count[IDX_W-1:0];
        end else if (i_cmd.shift_step) begin
            r_dst <= r_dst - IDX_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_stat.search_open = (r_lo < r_hi);
    assign o_stat.need_insert = (r_item.action == ACT_INSERT) & ~r_hit & ~w_full;
    assign o_stat.no_shift    = (r_count == r_lo);
    assign o_stat.shift_last  = (CNT_W'(r_dst) == r_lo + CNT_W'(1));
    assign o_stat.full        = w_full;
    assign o_stat.out_free    = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== rtl/skit_ctrl.sv =====
module skit_ctrl
    import skit_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_PROBE_RD   = 3'd1;
    localparam logic [2:0] S_PROBE_CMP  = 3'd2;
    localparam logic [2:0] S_DECIDE     = 3'd3;
    localparam logic [2:0] S_SHIFT_INIT = 3'd4;
    localparam logic [2:0] S_SHIFT      = 3'd5;
    localparam logic [2:0] S_WRITE      = 3'd6;
    localparam logic [2:0] S_DONE       = 3'd7;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                if (i_stat.search_open) begin
                    o_cmd.probe_rd = 1'b1;
                    n_state        = S_PROBE_CMP;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_PROBE_CMP: begin
                o_cmd.probe_cmp = 1'b1;
                n_state         = S_PROBE_RD;
            end
            S_DECIDE: begin
                o_cmd.set_result = 1'b1;
                n_state          = i_stat.need_insert ? S_SHIFT_INIT : S_DONE;
            end
            S_SHIFT_INIT: begin
                if (i_stat.no_shift) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // one entry moves up each cycle, read and write overlapped
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_new = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/sorted_key_index_table.sv =====
// channel  | handshake                  | word
// ---------+----------------------------+----------------------------------------
// input    | i_in_valid / o_in_ready    | i_in_word  (action, key, record_position)
// output   | o_out_valid / i_out_ready  | o_out_word (status, found_position)
//
// lookup: a binary search, each probe a read state then a compare state
// insert: the same, then the entries above the index shift up, one entry moved per cycle
//   through the separate read and write ports of the table memory, then the new entry is written
// one word in flight; the next word is taken while the last result waits
// synchronous active-low reset clears entry count and control; memory not cleared
module sorted_key_index_table
    import skit_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    skit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    skit_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    a_pos_only_when_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ST_FOUND) |-> o_out_word.found_position == '0)
        else $error("position reported without a match");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word accepted while busy");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !o_out_valid || i_out_ready)
        else $error("pending result overwritten");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.write_new |-> !w_stat.full)
        else $error("insert into a full table");

endmodule

// ===== tb/sv/sorted_key_index_table_test.sv =====
`timescale 1ns / 100ps

module sorted_key_index_table_test;
    import skit_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;
    localparam logic [KEY_W-1:0] DEC_MAX = 37'd99999999999;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    // shadow of the sorted table
    logic [KEY_W-1:0] shadow_key [TABLE_DEPTH];
    logic [POS_W-1:0] shadow_pos [TABLE_DEPTH];
    int               shadow_count;

    t_out_word expected_results [$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        error_count;
    int        stall_cycles;

    sorted_key_index_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // updates the shadow table and returns the result word the block should give
    function automatic t_out_word apply_to_table(t_in_word w);
        int        lo;
        int        hi;
        int        mid;
        bit        hit;
        t_out_word r;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (shadow_key[mid] < w.key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        hit = (lo < shadow_count) && (shadow_key[lo] == w.key);
        r.found_position = '0;
        if (w.action == ACT_LOOKUP) begin
            if (hit) begin
                r.status = ST_FOUND;
                r.found_position = shadow_pos[lo];
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end else if (hit) begin
            r.status = ST_DUPLICATE;
        end else if (shadow_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
        end else begin
            for (int i = shadow_count; i > lo; i--) begin
                shadow_key[i] = shadow_key[i-1];
                shadow_pos[i] = shadow_pos[i-1];
            end
            shadow_key[lo] = w.key;
            shadow_pos[lo] = w.record_position;
            shadow_count++;
            r.status = ST_INSERTED;
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] random_key(bit decimal_only);
        logic [31:0] hi_part;
        logic [31:0] lo_part;
        logic [63:0] wide;
        hi_part = $urandom();
        lo_part = $urandom();
        wide = {27'd0, hi_part[4:0], lo_part};
        if (decimal_only) begin
            wide = wide % 64'd100000000000;
        end
        return wide[KEY_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] stored_key();
        return shadow_key[$urandom_range(shadow_count - 1)];
    endfunction

    task automatic send_word(logic action, logic [KEY_W-1:0] key, logic [POS_W-1:0] pos);
        t_in_word w;
        w.action = action;
        w.key = key;
        w.record_position = pos;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        expected_results.push_back(apply_to_table(w));
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    task automatic test_empty_lookup();
        send_word(ACT_LOOKUP, '0, '0);
        send_word(ACT_LOOKUP, KEY_MAX, 16'hFFFF);
        send_word(ACT_LOOKUP, DEC_MAX, 16'h1234);
    endtask

    task automatic test_directed_entries();
        send_word(ACT_INSERT, 37'd50000000000, 16'd1234);
        send_word(ACT_INSERT, '0, 16'h0000);
        send_word(ACT_INSERT, KEY_MAX, 16'hFFFF);
        send_word(ACT_INSERT, DEC_MAX, 16'hAAAA);
        send_word(ACT_INSERT, DEC_MAX + 37'd1, 16'h5555);
        send_word(ACT_INSERT, 37'd1, 16'd1);
        send_word(ACT_INSERT, 37'd50000000001, 16'd2);
        send_word(ACT_INSERT, '0, 16'd7);
        send_word(ACT_INSERT, KEY_MAX, 16'd9);
        send_word(ACT_LOOKUP, '0, 16'hFFFF);
        send_word(ACT_LOOKUP, KEY_MAX, '0);
        send_word(ACT_LOOKUP, DEC_MAX, '0);
        send_word(ACT_LOOKUP, DEC_MAX + 37'd1, '0);
        send_word(ACT_LOOKUP, 37'd50000000000, '0);
        send_word(ACT_LOOKUP, 37'd50000000001, '0);
        send_word(ACT_LOOKUP, 37'd1, '0);
        send_word(ACT_LOOKUP, 37'd2, '0);
        send_word(ACT_LOOKUP, DEC_MAX - 37'd1, '0);
        send_word(ACT_LOOKUP, KEY_MAX - 37'd1, '0);
    endtask

    // mostly lookups of stored keys, their neighbours or random keys, with some inserts of new or stored keys
    task automatic test_random_mix(int count);
        int               mode;
        logic             action;
        logic [KEY_W-1:0] key;
        repeat (count) begin
            action = ($urandom_range(99) < 25) ? ACT_INSERT : ACT_LOOKUP;
            mode = $urandom_range(99);
            if (action == ACT_INSERT) begin
                if (mode < 30 && shadow_count > 0) begin
                    key = stored_key();
                end else begin
                    key = random_key(mode < 80);
                end
            end else if (mode < 60 && shadow_count > 0) begin
                key = stored_key();
            end else if (mode < 75 && shadow_count > 0) begin
                key = stored_key() + (mode[0] ? 37'd1 : KEY_MAX);
            end else begin
                key = random_key(mode < 90);
            end
            send_word(action, key, 16'($urandom()));
        end
    endtask

    task automatic test_full_table();
        while (shadow_count < TABLE_DEPTH) begin
            send_word(ACT_INSERT, random_key(1'($urandom_range(1))), 16'($urandom()));
        end
        send_word(ACT_INSERT, random_key(1'b1), 16'($urandom()));
        send_word(ACT_INSERT, KEY_MAX - 37'd2, 16'hFFFF);
        send_word(ACT_INSERT, '0, 16'h1111);
        send_word(ACT_INSERT, stored_key(), 16'h2222);
        send_word(ACT_LOOKUP, '0, '0);
        send_word(ACT_LOOKUP, KEY_MAX, '0);
        repeat (20) begin
            send_word(ACT_LOOKUP, stored_key(), 16'($urandom()));
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result check and stall watchdog
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result word status %0d position %0d",
                             $time, o_out_word.status, o_out_word.found_position);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_word.status !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, o_out_word.status);
                    end
                    if (o_out_word.found_position !== want.found_position) begin
                        error_count++;
                        $display("%0t: found_position expected %0d got %0d",
                                 $time, want.found_position, o_out_word.found_position);
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("[sorted_key_index_table] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        error_count = 0;
        stall_cycles = 0;
        shadow_count = 0;
        set_idling(8, 78);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_lookup();
        test_directed_entries();
        test_random_mix(400);
        set_idling(78, 8);
        test_random_mix(400);
        set_idling(0, 0);
        test_random_mix(400);
        test_full_table();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[sorted_key_index_table] OK");
        end else begin
            $display("[sorted_key_index_table] ERROR");
        end
        $finish;
    end

endmodule
